FILE: sv/rthp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rthp_pkg;

    localparam int PIX_W  = 8;              // one colour component
    localparam int HN_W   = 11;             // sextant position times d, up to 6 * 255
    localparam int NUM_W  = 20;             // dividend, up to 1530 * 471
    localparam int DEN_W  = 13;             // divisor, up to 20 * 255
    localparam int Q_W    = 8;              // quotient bits, one per divider stage
    localparam int CMP_W  = NUM_W + DEN_W;  // compare width, no overflow on shift
    localparam int LANES  = 2;

    localparam int LANE_SAT = 0;
    localparam int LANE_HUE = 1;

    localparam int HUE_MUL     = 471;       // 60 * 157 / 20
    localparam int HUE_DEN_MUL = 20;

    typedef logic [PIX_W-1:0]             pix_t;
    typedef logic [HN_W-1:0]              hn_t;
    typedef logic [LANES-1:0][NUM_W-1:0]  num_vec_t;
    typedef logic [LANES-1:0][DEN_W-1:0]  den_vec_t;
    typedef logic [LANES-1:0][Q_W-1:0]    quo_vec_t;

    typedef struct packed {
        pix_t     mx;
        num_vec_t num;
        den_vec_t den;
    } div_in_t;

    typedef struct packed {
        pix_t brightness;
        pix_t saturation;
        pix_t hue_code;
    } hsv_t;

endpackage

`default_nettype wire

FILE: sv/rthp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rthp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rthp_pkg::pix_t   red,
    input  wire rthp_pkg::pix_t   green,
    input  wire rthp_pkg::pix_t   blue,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rthp_pkg::div_in_t     out_data
);

    import rthp_pkg::*;

    // stage 1: extremes, spread and sextant position
    logic    s1_v_reg;
    pix_t    s1_mx_reg, s1_mx_next;
    pix_t    s1_d_reg,  s1_d_next;
    hn_t     s1_hn_reg, s1_hn_next;

    // stage 2: dividends and divisors
    logic    s2_v_reg;
    div_in_t s2_reg, s2_next;

    logic    en1, en2;

    assign en2      = !s2_v_reg || out_ready;
    assign en1      = !s1_v_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        pix_t mn;
        hn_t  dx;
        hn_t  six_d;
        hn_t  hn;
        s1_mx_next = (red > green) ? red : green;
        s1_mx_next = (s1_mx_next > blue) ? s1_mx_next : blue;
        mn         = (red < green) ? red : green;
        mn         = (mn < blue) ? mn : blue;
        s1_d_next  = s1_mx_next - mn;
        dx         = HN_W'(s1_d_next);
        six_d      = (dx << 2) + (dx << 1);
        // tie order: red first, then green, then blue
        if (red == s1_mx_next)
        begin
            if (green == mn)
                hn = (dx << 2) + dx + HN_W'(s1_mx_next - blue);
            else
                hn = dx - HN_W'(s1_mx_next - green);
        end
        else if (green == s1_mx_next)
        begin
            if (blue == mn)
                hn = dx + HN_W'(s1_mx_next - red);
            else
                hn = (dx << 1) + dx - HN_W'(s1_mx_next - blue);
        end
        else if (red == mn)
            hn = (dx << 1) + dx + HN_W'(s1_mx_next - green);
        else
            hn = (dx << 2) + dx - HN_W'(s1_mx_next - red);
        // cap at a full turn
        s1_hn_next = (hn > six_d) ? six_d : hn;
    end

    always_comb
    begin
        s2_next.mx            = s1_mx_reg;
        s2_next.num[LANE_SAT] = (NUM_W'(s1_d_reg) << 8) - NUM_W'(s1_d_reg);
        // black pixel: zero over one gives zero
        s2_next.den[LANE_SAT] = (s1_mx_reg == '0) ? DEN_W'(1) : DEN_W'(s1_mx_reg);
        if (s1_d_reg == '0)
        begin
            // grey pixel: hue is zero
            s2_next.num[LANE_HUE] = '0;
            s2_next.den[LANE_HUE] = DEN_W'(1);
        end
        else
        begin
            s2_next.num[LANE_HUE] = NUM_W'(s1_hn_reg) * NUM_W'(HUE_MUL);
            s2_next.den[LANE_HUE] = DEN_W'(s1_d_reg) * DEN_W'(HUE_DEN_MUL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= in_valid;
            if (en2)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mx_reg <= s1_mx_next;
            s1_d_reg  <= s1_d_next;
            s1_hn_reg <= s1_hn_next;
        end
        if (en2)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_v_reg;
    assign out_data  = s2_reg;

endmodule

`default_nettype wire

FILE: sv/rthp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rthp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rthp_pkg::div_in_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rthp_pkg::hsv_t         out_data
);

    import rthp_pkg::*;

    logic     [Q_W-1:0] v_reg;
    logic     [Q_W-1:0] en;
    quo_vec_t q_reg   [Q_W];
    pix_t     mx_reg  [Q_W];
    num_vec_t rem_reg [Q_W-1];
    den_vec_t den_reg [Q_W-1];

    assign in_ready = en[0];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;

        num_vec_t rem_in;
        den_vec_t den_in;
        quo_vec_t q_in;
        pix_t     mx_in;
        logic     v_in;
        quo_vec_t q_next;
        logic     [CMP_W-1:0] shifted [LANES];
        logic     [LANES-1:0] ge;

        if (k == 0)
        begin : g_first
            assign rem_in = in_data.num;
            assign den_in = in_data.den;
            assign q_in   = '0;
            assign mx_in  = in_data.mx;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign mx_in  = mx_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        if (k == Q_W - 1)
        begin : g_en_last
            assign en[k] = !v_reg[k] || out_ready;
        end
        else
        begin : g_en_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end

        // one restoring step per lane: try the divisor at this bit weight
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                shifted[l] = CMP_W'(den_in[l]) << B;
                ge[l]      = CMP_W'(rem_in[l]) >= shifted[l];
                q_next[l]  = q_in[l] | (Q_W'(ge[l]) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                q_reg[k]  <= q_next;
                mx_reg[k] <= mx_in;
            end
        end

        if (k < Q_W - 1)
        begin : g_keep
            num_vec_t rem_next;

            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                    rem_next[l] = ge[l] ? (rem_in[l] - shifted[l][NUM_W-1:0]) : rem_in[l];
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign out_valid           = v_reg[Q_W-1];
    assign out_data.hue_code   = q_reg[Q_W-1][LANE_HUE];
    assign out_data.saturation = q_reg[Q_W-1][LANE_SAT];
    assign out_data.brightness = mx_reg[Q_W-1];

endmodule

`default_nettype wire

FILE: sv/rgb_to_hsv_pixel_pack.sv
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSV pixel converter, one pixel per transaction on each side.
// Slave channel s_*: one RGB pixel per transaction. Master channel m_*: the
// same pixel packed as HSV (hue code in the low byte, then saturation, then
// brightness, i.e. the largest component).
// Hue code is floor(degrees * 157 / 400), 0 to 141; grey pixels give hue 0,
// black pixels give saturation 0.
// Pipeline: ten register stages, the first loaded at the edge that takes a
// transaction on the slave side: two front stages (extremes and sextant, then
// dividends and divisors via small constant multiplies) and eight restoring
// divider stages, one quotient bit each, with saturation and hue divided side
// by side in the same stages.
// Throughput: one pixel per cycle, sustained, while m_tready stays high.
// Stall: each stage holds while it is full and the stage after it cannot
// take; empty stages still fill, so s_tready drops only once every stage
// ahead is occupied. Nothing is dropped or repeated.
// Reset: rst_n clears all valid bits asynchronously; the pipeline comes up
// empty and ready.

module rgb_to_hsv_pixel_pack (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // hue_code [7:0], saturation [15:8], brightness [23:16]
);

    import rthp_pkg::*;

    logic    front_valid;
    logic    front_ready;
    div_in_t front_data;
    hsv_t    result;

    // extremes, sextant position, dividends and divisors
    rthp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // both quotients, bit by bit; the last stage is the output register
    rthp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = result;

endmodule

`default_nettype wire

FILE: sv/rthp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rthp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] <= 8'd141)
        else $error("hue code above full turn");

    // black pixel: nothing but zeros
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23:16] == 8'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("black pixel with hue or saturation");

    // any hue needs a spread, and a spread gives saturation of at least one
    a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[15:8] != 8'd0)
        else $error("hue without saturation");

    // an empty pipeline after reset takes a pixel at once
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> s_tready)
        else $error("not ready after reset");

endmodule

bind rgb_to_hsv_pixel_pack rthp_checker u_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import rthp_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 16;        // pipeline is 10 deep, leave some slack
    localparam int TIMEOUT_NS     = 2_000_000;
    localparam int PIX_MAX        = (1 << PIX_W) - 1;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // red [7:0], green [15:8], blue [23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // hue_code [7:0], saturation [15:8], brightness [23:16]

    hsv_t pending_hsv[$];
    int   hsv_errors       = 0;
    int   pixels_sent      = 0;
    int   pixels_checked   = 0;
    int   stalled_offers   = 0;
    int   send_idle_pct    = 0;
    int   recv_stall_pct   = 0;
    int   ready_hold_off   = 0;

    rgb_to_hsv_pixel_pack DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #HALF_PERIOD_NS clk = 1'b1;
        #HALF_PERIOD_NS clk = 1'b0;
    end

    // Integer HSV conversion; every quotient is truncated once, at the end.
    function automatic hsv_t predict_hsv(input pix_t red, input pix_t green, input pix_t blue);
        int unsigned mx;
        int unsigned mn;
        int unsigned d;
        int unsigned hn;
        hsv_t        res;
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        d  = mx - mn;
        res.brightness = pix_t'(mx);
        res.saturation = (mx != 0) ? pix_t'((PIX_MAX * d) / mx) : '0;
        res.hue_code   = '0;
        if (d != 0)
        begin
            // sextant position scaled by d, tie order: red, then green, then blue
            if (red == mx)
                hn = (green == mn) ? 5 * d + (mx - blue) : d - (mx - green);
            else if (green == mx)
                hn = (blue == mn) ? d + (mx - red) : 3 * d - (mx - blue);
            else if (red == mn)
                hn = 3 * d + (mx - green);
            else
                hn = 5 * d - (mx - red);
            if (hn > 6 * d)
                hn = 6 * d;
            res.hue_code = pix_t'((hn * HUE_MUL) / (HUE_DEN_MUL * d));
        end
        return res;
    endfunction

    // Offer one pixel; return at the rising edge that takes it.
    task automatic send_pixel(input pix_t red, input pix_t green, input pix_t blue);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            if (!taken)
                stalled_offers++;
            @(posedge clk);
        end
        while (!taken);
        pending_hsv.push_back(predict_hsv(red, green, blue));
        pixels_sent++;
    endtask

    // Drop valid and hold until every expected pixel has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extreme_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // grey
        send_pixel(8'd255, 8'd0,   8'd128);   // red max, green min
        send_pixel(8'd255, 8'd128, 8'd0);     // red max, blue min
        send_pixel(8'd128, 8'd255, 8'd0);     // green max, blue min
        send_pixel(8'd0,   8'd255, 8'd128);   // green max, red min
        send_pixel(8'd0,   8'd128, 8'd255);   // blue max, red min
        send_pixel(8'd128, 8'd0,   8'd255);   // blue max, green min
        send_pixel(8'd255, 8'd0,   8'd0);     // pure red, hue at the cap
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);     // red and green share the max
        send_pixel(8'd0,   8'd255, 8'd255);   // green and blue share the max
        send_pixel(8'd255, 8'd0,   8'd255);   // red and blue share the max
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd1,   8'd0);
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count)
            send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    endtask

    // Draw components from a tiny pool so that max and min ties are common.
    task automatic test_tied_components(input int count);
        pix_t comp[3];
        pix_t shared;
        repeat (count)
        begin
            shared = pix_t'($urandom);
            foreach (comp[k])
                case ($urandom_range(3))
                    0:       comp[k] = '0;
                    1:       comp[k] = pix_t'(PIX_MAX);
                    default: comp[k] = shared;
                endcase
            send_pixel(comp[0], comp[1], comp[2]);
        end
    endtask

    // Small spreads stress the divider near grey and the hue boundaries.
    task automatic test_near_grey(input int count);
        pix_t comp[3];
        int   base;
        int   v;
        repeat (count)
        begin
            base = $urandom_range(PIX_MAX);
            foreach (comp[k])
            begin
                v = base + $urandom_range(6) - 3;
                if (v < 0)       v = 0;
                if (v > PIX_MAX) v = PIX_MAX;
                comp[k] = pix_t'(v);
            end
            send_pixel(comp[0], comp[1], comp[2]);
        end
    endtask

    // Hold the output off long enough for the pipeline to fill and push back.
    task automatic test_output_hold_off(input int count);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_hold_off = 80;
        test_random_pixels(count);
    endtask

    task automatic run_idle_phase(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        test_random_pixels(60);
        test_tied_components(30);
        test_near_grey(20);
        wait_for_results();
    endtask

    always @(posedge clk)
    begin
        if (ready_hold_off > 0)
        begin
            ready_hold_off = ready_hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample half a cycle early so the check never races the edge.
    always @(negedge clk)
    begin
        hsv_t want;
        hsv_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = hsv_t'(m_tdata);
            if (pending_hsv.size() == 0)
            begin
                $error("unexpected result %h with nothing pending", m_tdata);
                hsv_errors++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                pixels_checked++;
                if (got.hue_code !== want.hue_code)
                begin
                    $error("hue_code: expected %0d, got %0d", want.hue_code, got.hue_code);
                    hsv_errors++;
                end
                if (got.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, got.saturation);
                    hsv_errors++;
                end
                if (got.brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, got %0d",
                           want.brightness, got.brightness);
                    hsv_errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_pixels();
        wait_for_results();

        run_idle_phase(0, 0);
        run_idle_phase(48, 0);
        run_idle_phase(0, 48);
        run_idle_phase(30, 30);

        test_output_hold_off(40);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_hsv.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_hsv.size());
            hsv_errors++;
        end

        $display("Converted %0d pixels (corners, ties, near-grey, random) under four idle mixes,",
                 pixels_sent);
        $display("checked %0d results; input was pushed back on %0d offered cycles.",
                 pixels_checked, stalled_offers);
        if (hsv_errors == 0)
            $display("rgb_to_hsv_pixel_pack test passed");
        else
            $display("rgb_to_hsv_pixel_pack test failed");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", pending_hsv.size());
        $display("rgb_to_hsv_pixel_pack test failed");
        $finish;
    end

endmodule
